>>> rtl/tme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tme_pkg
// Types and constants shared by the tape machine executor.
// ============================================================================
package tme_pkg;

    localparam int TAPE_CELLS   = 4096;
    localparam int START_CELL   = 500;
    localparam int ADDRESS_BITS = 16;

    localparam int PTR_W = $clog2(TAPE_CELLS);
    // signed width for pointer plus 16-bit signed amount
    localparam int SUM_W = ((PTR_W > 15) ? PTR_W : 15) + 2;

    localparam logic [PTR_W-1:0] START_PTR = PTR_W'(START_CELL % TAPE_CELLS);
    localparam logic [15:0] ADDR_MASK = 16'((64'd1 << ADDRESS_BITS) - 64'd1);

    typedef enum logic [2:0] {
        KIND_MOVE     = 3'd0,
        KIND_ADD      = 3'd1,
        KIND_JUMP_Z   = 3'd2,
        KIND_JUMP_NZ  = 3'd3,
        KIND_INPUT    = 3'd4,
        KIND_OUTPUT   = 3'd5,
        KIND_END      = 3'd6
    } kind_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] amount;
        logic [7:0]         in_byte;
        logic [15:0]        jump_target;
        logic [15:0]        fall_through;
    } cmd_item_t;

    typedef struct packed {
        logic [15:0] next_address;
        logic        jump_taken;
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        halted;
        logic        pointer_wrapped;
    } res_item_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic             active;
        logic [PTR_W-1:0] addr;
        logic [7:0]       amount_lo;
        logic [7:0]       in_byte;
        logic [15:0]      jump_target;
        logic [15:0]      fall_through;
        logic             wrapped;
        logic             halted;
    } exec_stage_t;

endpackage
`default_nettype wire

>>> rtl/tape_machine_executor_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tape_machine_executor_top
// Executes one decoded tape machine instruction per item on a byte tape.
// ============================================================================
//  channel | dir | handshake            | payload
//  cmd     | in  | cmd_valid/cmd_stall  | tme_pkg::cmd_item_t (one instruction)
//  res     | out | res_valid/res_stall  | tme_pkg::res_item_t (one result)
//
//  One item per cycle sustained while cmd_stall is low; each result passes the
//  tape read, then execute and write back into a two-entry output queue.
//  A read of a cell written by the item just before is forwarded from that write.
//  After reset the tape is cleared one cell a cycle, all TAPE_CELLS (4096) cells,
//  with cmd_stall high. A stalled res side fills the queue, then cmd_stall.
// ============================================================================
module tape_machine_executor_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire tme_pkg::cmd_item_t cmd_item,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output tme_pkg::res_item_t      res_item
);

    localparam int PW = tme_pkg::PTR_W;
    localparam int SW = tme_pkg::SUM_W;

    logic [7:0] tape_mem [tme_pkg::TAPE_CELLS];

    logic          clearing_reg;
    logic [PW-1:0] clr_addr_reg;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic          halt_reg, halt_next;

    logic                 s1_valid_reg;
    tme_pkg::exec_stage_t s1_reg, s1_next;
    logic [7:0]           rd_data_reg;

    logic          lw_valid_reg;
    logic [PW-1:0] lw_addr_reg;
    logic [7:0]    lw_data_reg;

    tme_pkg::res_item_t q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    logic accept, pop;
    logic [2:0] occ;
    logic signed [SW-1:0] sum;
    logic wrap;
    logic [7:0] cur_byte;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [7:0]    wr_data;
    tme_pkg::res_item_t res_calc;

    assign pop       = res_valid && !res_stall;
    assign occ       = {1'b0, count_reg} + {2'b00, s1_valid_reg} - {2'b00, pop};
    assign cmd_stall = clearing_reg || (occ > 3'd1);
    assign accept    = cmd_valid && !cmd_stall;

    // pointer and halt update at accept
    always_comb
    begin
        sum  = SW'($signed({1'b0, ptr_reg})) + SW'(cmd_item.amount);
        wrap = (sum < 0) || (sum >= SW'(tme_pkg::TAPE_CELLS));
        ptr_next  = ptr_reg;
        halt_next = halt_reg;
        if (accept && !halt_reg)
        begin
            if (cmd_item.kind == tme_pkg::KIND_MOVE)
                ptr_next = sum[PW-1:0];
            if (cmd_item.kind == tme_pkg::KIND_END)
                halt_next = 1'b1;
        end
        s1_next.kind         = cmd_item.kind;
        s1_next.active       = !halt_reg;
        s1_next.addr         = ptr_reg;
        s1_next.amount_lo    = cmd_item.amount[7:0];
        s1_next.in_byte      = cmd_item.in_byte;
        s1_next.jump_target  = cmd_item.jump_target;
        s1_next.fall_through = cmd_item.fall_through;
        s1_next.wrapped      = !halt_reg && (cmd_item.kind == tme_pkg::KIND_MOVE) && wrap;
        s1_next.halted       = halt_next;
    end

    // execute stage
    always_comb
    begin
        cur_byte = (lw_valid_reg && (lw_addr_reg == s1_reg.addr)) ? lw_data_reg : rd_data_reg;
        res_calc.jump_taken      = 1'b0;
        res_calc.out_valid       = 1'b0;
        res_calc.out_byte        = 8'd0;
        res_calc.halted          = s1_reg.halted;
        res_calc.pointer_wrapped = s1_reg.wrapped;
        wr_en   = 1'b0;
        wr_data = s1_reg.in_byte;
        if (s1_reg.active)
        begin
            case (s1_reg.kind)
                tme_pkg::KIND_ADD:
                begin
                    wr_en   = 1'b1;
                    wr_data = cur_byte + s1_reg.amount_lo;
                end
                tme_pkg::KIND_JUMP_Z:  res_calc.jump_taken = (cur_byte == 8'd0);
                tme_pkg::KIND_JUMP_NZ: res_calc.jump_taken = (cur_byte != 8'd0);
                tme_pkg::KIND_INPUT:   wr_en = 1'b1;
                tme_pkg::KIND_OUTPUT:
                begin
                    res_calc.out_valid = 1'b1;
                    res_calc.out_byte  = cur_byte;
                end
                default: ;
            endcase
        end
        wr_en = wr_en && s1_valid_reg;
        res_calc.next_address = (res_calc.jump_taken ? s1_reg.jump_target
                                                     : s1_reg.fall_through)
                                & tme_pkg::ADDR_MASK;
        wr_addr = s1_reg.addr;
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            tape_mem[clr_addr_reg] <= 8'd0;
        else if (wr_en)
            tape_mem[wr_addr] <= wr_data;
        if (accept)
            rd_data_reg <= tape_mem[ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
        lw_addr_reg <= wr_addr;
        lw_data_reg <= wr_data;
        if (s1_valid_reg)
            q_reg[wr_ptr_reg] <= res_calc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            ptr_reg      <= tme_pkg::START_PTR;
            halt_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            count_reg    <= 2'd0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + PW'(1);
                if (clr_addr_reg == PW'(tme_pkg::TAPE_CELLS - 1))
                    clearing_reg <= 1'b0;
            end
            ptr_reg      <= ptr_next;
            halt_reg     <= halt_next;
            s1_valid_reg <= accept;
            lw_valid_reg <= wr_en;
            if (s1_valid_reg)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= occ[1:0];
        end
    end

    assign res_valid = (count_reg != 2'd0);
    assign res_item  = q_reg[rd_ptr_reg];

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("output queue overflow");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !pop) |-> (count_reg < 2'd2))
        else $error("push into full queue");

    a_no_exec_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s1_valid_reg)
        else $error("item executed during tape clear");

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag dropped");

    a_wrap_on_move: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_reg.wrapped) |-> (s1_reg.kind == tme_pkg::KIND_MOVE))
        else $error("wrap flagged on non-move");

endmodule
`default_nettype wire

>>> tb/sv/tape_machine_executor_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// tape_machine_executor_checker
// Watches the cmd and res channels of the tape machine executor and keeps
// its own tape, cell pointer and halt flag. Every accepted instruction is
// executed on that copy, and the result it gives is queued. Every accepted
// result is compared field by field with the oldest queued one.
// ============================================================================
module tape_machine_executor_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire logic               cmd_stall,
    input  wire tme_pkg::cmd_item_t cmd_item,
    input  wire logic               res_valid,
    input  wire logic               res_stall,
    input  wire tme_pkg::res_item_t res_item,
    output int                      errors,
    output int                      pending,
    output int                      checked,
    output int                      wraps
);
    import tme_pkg::*;

    logic [7:0]       tape_mem [TAPE_CELLS];
    logic [PTR_W-1:0] head;
    logic             halt_seen;
    res_item_t        result_q [$];

    function automatic res_item_t execute_instr(input cmd_item_t c);
        res_item_t r;
        int        np;
        logic [7:0] cur_byte;
        r = '0;
        cur_byte = tape_mem[head];
        if (!halt_seen)
        begin
            case (c.kind)
                KIND_MOVE:
                begin
                    np = int'(head) + int'($signed(c.amount));
                    if (np < 0 || np >= TAPE_CELLS)
                    begin
                        r.pointer_wrapped = 1'b1;
                        np = np % TAPE_CELLS;
                        if (np < 0)
                            np = np + TAPE_CELLS;
                    end
                    head = PTR_W'(np);
                end
                KIND_ADD:     tape_mem[head] = cur_byte + c.amount[7:0];
                KIND_JUMP_Z:  r.jump_taken = (cur_byte == 8'd0);
                KIND_JUMP_NZ: r.jump_taken = (cur_byte != 8'd0);
                KIND_INPUT:   tape_mem[head] = c.in_byte;
                KIND_OUTPUT:
                begin
                    r.out_valid = 1'b1;
                    r.out_byte  = cur_byte;
                end
                KIND_END:     halt_seen = 1'b1;
                default:      ;
            endcase
        end
        r.next_address = (r.jump_taken ? c.jump_target : c.fall_through) & ADDR_MASK;
        r.halted = halt_seen;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TAPE_CELLS; i++)
                tape_mem[i] = 8'd0;
            head = START_PTR;
            halt_seen = 1'b0;
            result_q.delete();
            errors = 0;
            pending = 0;
            checked = 0;
            wraps = 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                want = execute_instr(cmd_item);
                if (want.pointer_wrapped)
                    wraps++;
                result_q.push_back(want);
            end
            if (res_valid && !res_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result item with nothing expected, next_address 0x%0h",
                           res_item.next_address);
                    errors++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("next_address", want.next_address, res_item.next_address);
                    check_field("jump_taken", want.jump_taken, res_item.jump_taken);
                    check_field("out_valid", want.out_valid, res_item.out_valid);
                    check_field("out_byte", want.out_byte, res_item.out_byte);
                    check_field("halted", want.halted, res_item.halted);
                    check_field("pointer_wrapped", want.pointer_wrapped,
                                res_item.pointer_wrapped);
                    checked++;
                end
            end
            pending = result_q.size();
        end
    end

endmodule

>>> tb/sv/tape_machine_executor_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tape_machine_executor_top_tb
// Drives instruction items into the tape machine executor: a directed set of
// edge cases, then random instruction mixes with countdown loops, then halt
// and items after halt. Both sides idle in random bursts. The checker module
// predicts and compares; this module makes stimulus and gives the verdict.
// ============================================================================
module tape_machine_executor_top_tb;
    import tme_pkg::*;

    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int IDLE_LIMIT      = 20000;
    localparam int RANDOM_ITEMS    = 550;
    localparam int QUIET_ITEMS     = 150;
    localparam int POST_HALT_ITEMS = 24;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_item_t cmd_item;
    logic      res_valid;
    logic      res_stall;
    res_item_t res_item;

    int errors;
    int pending;
    int checked;
    int wraps;
    int sent;
    int idle_cycles;
    bit idle_en;

    tape_machine_executor_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    tape_machine_executor_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .wraps     (wraps)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // watchdog: cycles with no item accepted on either channel
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles = 0;
        else
        begin
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tape_machine_executor_top_tb: FAIL");
                $finish;
            end
        end
    end

    // res side stall bursts
    initial
    begin
        bit stall_val;
        res_stall = 1'b0;
        forever
        begin
            stall_val = idle_en && ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(1, 15))
            begin
                @(negedge clk);
                res_stall <= stall_val;
            end
        end
    end

    function automatic cmd_item_t make_instr(input logic [2:0] k, input int amt,
                                             input logic [7:0] b);
        cmd_item_t c;
        c.kind         = k;
        c.amount       = 16'(amt);
        c.in_byte      = b;
        c.jump_target  = 16'($urandom);
        c.fall_through = 16'($urandom);
        return c;
    endfunction

    function automatic cmd_item_t rand_instr();
        cmd_item_t c;
        int        r;
        int        pick;
        c = make_instr(KIND_MOVE, int'($urandom), 8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 26)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 16)
                c.amount = 16'(int'($urandom_range(0, 8)) - 4);
            else if (pick < 19)
                c.amount = 16'(int'($urandom_range(0, 1200)) - 600);
        end
        else if (r < 50)
        begin
            c.kind = KIND_ADD;
            if ($urandom_range(0, 1) == 1)
                c.amount = 16'(int'($urandom_range(0, 6)) - 3);
        end
        else if (r < 60)
            c.kind = KIND_JUMP_Z;
        else if (r < 70)
            c.kind = KIND_JUMP_NZ;
        else if (r < 80)
        begin
            c.kind = KIND_INPUT;
            if ($urandom_range(0, 4) == 0)
                c.in_byte = 8'd0;
        end
        else if (r < 96)
            c.kind = KIND_OUTPUT;
        else
            c.kind = KIND_UNUSED;
        return c;
    endfunction

    task automatic send_instr(input cmd_item_t c);
        @(negedge clk);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // load a small count, then decrement and jump-if-nonzero until zero, then jump-if-zero
    task automatic send_countdown();
        int n;
        n = $urandom_range(1, 6);
        send_instr(make_instr(KIND_INPUT, int'($urandom), 8'(n)));
        repeat (n)
        begin
            send_instr(make_instr(KIND_ADD, -1, 8'($urandom)));
            send_instr(make_instr(KIND_JUMP_NZ, int'($urandom), 8'($urandom)));
        end
        send_instr(make_instr(KIND_JUMP_Z, int'($urandom), 8'($urandom)));
    endtask

    initial
    begin
        cmd_item_t c;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_item  = '0;
        idle_en   = 1'b1;
        sent      = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed: cleared cell, branch address extremes, add wrap, pointer wrap
        send_instr(make_instr(KIND_OUTPUT, 0, 8'h00));
        c = make_instr(KIND_JUMP_Z, 0, 8'h00);
        c.jump_target  = 16'hFFFF;
        c.fall_through = 16'h0000;
        send_instr(c);
        c = make_instr(KIND_JUMP_NZ, 0, 8'hFF);
        c.jump_target  = 16'h0000;
        c.fall_through = 16'hFFFF;
        send_instr(c);
        send_instr(make_instr(KIND_ADD, 32767, 8'h00));
        send_instr(make_instr(KIND_ADD, -32768, 8'h00));
        send_instr(make_instr(KIND_ADD, 1, 8'h00));
        send_instr(make_instr(KIND_ADD, -1, 8'h00));
        send_instr(make_instr(KIND_OUTPUT, 0, 8'h00));
        send_instr(make_instr(KIND_JUMP_NZ, 0, 8'h00));
        send_instr(make_instr(KIND_INPUT, 0, 8'h00));
        send_instr(make_instr(KIND_JUMP_Z, 0, 8'h00));
        send_instr(make_instr(KIND_INPUT, 0, 8'hFF));
        send_instr(make_instr(KIND_OUTPUT, 0, 8'h00));
        send_instr(make_instr(KIND_MOVE, -START_CELL, 8'h00));
        send_instr(make_instr(KIND_MOVE, -1, 8'h00));
        send_instr(make_instr(KIND_MOVE, 1, 8'h00));
        send_instr(make_instr(KIND_MOVE, TAPE_CELLS - 1, 8'h00));
        send_instr(make_instr(KIND_OUTPUT, 0, 8'h00));
        send_instr(make_instr(KIND_MOVE, 32767, 8'h00));
        send_instr(make_instr(KIND_MOVE, -32768, 8'h00));
        send_instr(make_instr(KIND_MOVE, 0, 8'h00));
        send_instr(make_instr(KIND_UNUSED, 0, 8'h00));
        send_instr(make_instr(KIND_ADD, 5, 8'h00));
        send_instr(make_instr(KIND_ADD, 7, 8'h00));
        send_instr(make_instr(KIND_OUTPUT, 0, 8'h00));
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                idle_en = 1'b0;
            if ($urandom_range(0, 9) == 0)
                send_countdown();
            else
                send_instr(rand_instr());
        end

        send_instr(make_instr(KIND_END, int'($urandom), 8'($urandom)));
        for (int i = 0; i < POST_HALT_ITEMS; i++)
        begin
            c = rand_instr();
            if ($urandom_range(0, 5) == 0)
                c.kind = KIND_END;
            send_instr(c);
        end
        drain_results();
        repeat (8) @(posedge clk);

        $display("Ran %0d instructions incl. halt and %0d after it; %0d results compared,",
                 sent, POST_HALT_ITEMS, checked);
        $display("%0d pointer wraps, idle bursts on both channels.", wraps);
        if (errors == 0 && pending == 0)
            $display("tape_machine_executor_top_tb: PASS");
        else
            $display("tape_machine_executor_top_tb: FAIL");
        $finish;
    end

endmodule
